[hw/rtl/rsbk_pkg.sv]
`timescale 1ns / 1ps

package rsbk_pkg;

   typedef struct packed {
      logic signed [31:0] key;
      logic [7:0]         age;
      logic [63:0]        name_first;
      logic [63:0]        name_middle;
      logic [31:0]        name_tail;
   } record_type;

   localparam int RecordWidth = $bits(record_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_CUR,
      ST_CAP_CUR,
      ST_SCAN,
      ST_WR_CUR,
      ST_EMIT_LOAD,
      ST_EMIT_HOLD
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_cur;
      logic cap_cur;
      logic scan;
      logic wr_cur;
      logic emit_start;
      logic emit_load;
      logic emit_next;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic outer_done;
      logic scan_last;
      logic emit_last;
      logic rsp_xfer;
   } status_type;

endpackage

[hw/rtl/rsbk_req_if.sv]
`timescale 1ns / 1ps

interface rsbk_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] key;
   logic [7:0]         age;
   logic [63:0]        name_first;
   logic [63:0]        name_middle;
   logic [31:0]        name_tail;
   logic               last_in;

   modport source (
      output valid, key, age, name_first, name_middle, name_tail, last_in,
      input  ready
   );

   modport sink (
      input  valid, key, age, name_first, name_middle, name_tail, last_in,
      output ready
   );
endinterface

[hw/rtl/rsbk_rsp_if.sv]
`timescale 1ns / 1ps

interface rsbk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] sorted_key;
   logic [7:0]         sorted_age;
   logic [63:0]        sorted_name_first;
   logic [63:0]        sorted_name_middle;
   logic [31:0]        sorted_name_tail;
   logic               last_out;
   logic               overflow;

   modport source (
      output valid, sorted_key, sorted_age, sorted_name_first, sorted_name_middle,
             sorted_name_tail, last_out, overflow,
      input  ready
   );

   modport sink (
      input  valid, sorted_key, sorted_age, sorted_name_first, sorted_name_middle,
             sorted_name_tail, last_out, overflow,
      output ready
   );
endinterface

[hw/rtl/record_sort_by_key_core.sv]
`timescale 1ns / 1ps

// Collects records one per req transfer, up to DEPTH per set (extra records are
// dropped and flag overflow on every emitted record of that set). A record is
// taken every cycle while loading. The transfer marked last_in starts an
// exchange sort by signed Q23.8 key over the n stored records, run by a state
// machine around one single-port-read record RAM: the candidate for position i
// sits in a register and each later record costs one RAM read and compare per
// cycle. The n sorted records then leave on rsp one at a time, each held until
// rsp_bus.ready takes it, the last one marked last_out. No new record is taken
// until the final rsp transfer of the set; the RAM needs no clearing after reset.

module record_sort_by_key_core #(
   parameter int DEPTH = 32
) (
   input  logic            clock,
   input  logic            reset,
   rsbk_req_if.sink        req_bus,
   rsbk_rsp_if.source      rsp_bus
);

   import rsbk_pkg::*;

   cmd_type    cmd;
   status_type status;
   record_type req_rec;
   record_type rsp_rec;

   assign req_rec = '{
      key:         req_bus.key,
      age:         req_bus.age,
      name_first:  req_bus.name_first,
      name_middle: req_bus.name_middle,
      name_tail:   req_bus.name_tail
   };

   rsbk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last_in),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_bus.ready)
   );

   rsbk_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_rec      (req_rec),
      .req_last     (req_bus.last_in),
      .rsp_rec      (rsp_rec),
      .rsp_last     (rsp_bus.last_out),
      .rsp_overflow (rsp_bus.overflow),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready)
   );

   assign rsp_bus.sorted_key         = rsp_rec.key;
   assign rsp_bus.sorted_age         = rsp_rec.age;
   assign rsp_bus.sorted_name_first  = rsp_rec.name_first;
   assign rsp_bus.sorted_name_middle = rsp_rec.name_middle;
   assign rsp_bus.sorted_name_tail   = rsp_rec.name_tail;

endmodule

[hw/rtl/rsbk_ram.sv]
`timescale 1ns / 1ps

module rsbk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/rsbk_ctrl.sv]
`timescale 1ns / 1ps

module rsbk_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   input  rsbk_pkg::status_type status,
   output rsbk_pkg::cmd_type    cmd,
   output logic                 req_ready
);

   import rsbk_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_RD_CUR;
               end
            end
         end
         ST_RD_CUR: begin
            if (status.outer_done) begin
               cmd.emit_start = 1'b1;
               state_in       = ST_EMIT_LOAD;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = ST_CAP_CUR;
            end
         end
         ST_CAP_CUR: begin
            cmd.cap_cur = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WR_CUR;
            end
         end
         ST_WR_CUR: begin
            cmd.wr_cur = 1'b1;
            state_in   = ST_RD_CUR;
         end
         ST_EMIT_LOAD: begin
            cmd.emit_load = 1'b1;
            state_in      = ST_EMIT_HOLD;
         end
         ST_EMIT_HOLD: begin
            if (status.rsp_xfer) begin
               if (status.emit_last) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end else begin
                  cmd.emit_next = 1'b1;
                  state_in      = ST_EMIT_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/rsbk_datapath.sv]
`timescale 1ns / 1ps

module rsbk_datapath #(
   parameter int DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsbk_pkg::cmd_type    cmd,
   output rsbk_pkg::status_type status,
   input  rsbk_pkg::record_type req_rec,
   input  logic                 req_last,
   output rsbk_pkg::record_type rsp_rec,
   output logic                 rsp_last,
   output logic                 rsp_overflow,
   output logic                 rsp_valid,
   input  logic                 rsp_ready
);

   import rsbk_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] k_ff, k_in;
   logic          out_valid_ff, out_valid_in;

   record_type    cur_ff, cur_in;
   record_type    out_ff, out_in;
   logic          out_last_ff, out_last_in;
   logic          out_ovf_ff, out_ovf_in;

   logic [CW-1:0] i_next, j_next, k_next;
   logic          full;
   logic          greater;
   logic          rsp_xfer;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   record_type       wr_data;
   logic [AW-1:0]    rd_addr;
   logic [RecordWidth-1:0] rd_raw;
   record_type       rd_rec;

   rsbk_ram #(
      .WIDTH (RecordWidth),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_rec   = rd_raw;
   assign i_next   = i_ff + CW'(1);
   assign j_next   = j_ff + CW'(1);
   assign k_next   = k_ff + CW'(1);
   assign full     = (count_ff == CW'(DEPTH));
   assign greater  = $signed(cur_ff.key) > $signed(rd_rec.key);
   assign rsp_xfer = out_valid_ff & rsp_ready;

   assign status.outer_done = (i_next >= count_ff);
   assign status.scan_last  = (j_next == count_ff);
   assign status.emit_last  = (k_next == count_ff);
   assign status.rsp_xfer   = rsp_xfer;

   always_comb begin
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff;
      cur_in       = cur_ff;
      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[AW-1:0];
      wr_data      = req_rec;
      rd_addr      = i_ff[AW-1:0];

      if (cmd.load) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            wr_en    = 1'b1;
            count_in = count_ff + CW'(1);
         end
         if (req_last) begin
            i_in = '0;
         end
      end

      if (cmd.rd_cur) begin
         rd_addr = i_ff[AW-1:0];
      end

      if (cmd.cap_cur) begin
         cur_in  = rd_rec;
         j_in    = i_next;
         rd_addr = i_next[AW-1:0];
      end

      if (cmd.scan) begin
         if (greater) begin
            wr_en   = 1'b1;
            wr_addr = j_ff[AW-1:0];
            wr_data = cur_ff;
            cur_in  = rd_rec;
         end
         if (!status.scan_last) begin
            j_in    = j_next;
            rd_addr = j_next[AW-1:0];
         end
      end

      if (cmd.wr_cur) begin
         wr_en   = 1'b1;
         wr_addr = i_ff[AW-1:0];
         wr_data = cur_ff;
         i_in    = i_next;
      end

      if (cmd.emit_start) begin
         k_in    = '0;
         rd_addr = '0;
      end

      if (cmd.emit_load) begin
         out_in       = rd_rec;
         out_last_in  = status.emit_last;
         out_ovf_in   = dropped_ff;
         out_valid_in = 1'b1;
      end

      if (rsp_xfer) begin
         out_valid_in = 1'b0;
      end

      if (cmd.emit_next) begin
         k_in    = k_next;
         rd_addr = k_next[AW-1:0];
      end

      if (cmd.finish) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_rec      = out_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_overflow = out_ovf_ff;
   assign rsp_valid    = out_valid_ff;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import rsbk_pkg::*;

   localparam int DEPTH       = 32;
   localparam int LOAD_ITEMS  = 400;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 300;

   localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

   typedef struct {
      record_type rec;
      bit         last_in;
   } load_item_type;

   typedef struct {
      record_type rec;
      bit         last_out;
      bit         overflow;
   } sorted_entry_type;

   logic clock;
   logic reset;

   rsbk_req_if req_bus ();
   rsbk_rsp_if rsp_bus ();

   record_sort_by_key_core #(.DEPTH(DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   load_item_type    load_q[$];
   sorted_entry_type sorted_q[$];

   record_type held[DEPTH];
   int         held_count;
   bit         dropped;

   int total_items;
   int taken_count;
   int mismatches;
   bit req_live;
   int hold_left;
   bit hold_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] pick_name64();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [31:0] pick_name32();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(9))
         0: return KEY_MAX;
         1: return KEY_MIN;
         2: return 32'sd0;
         3: return -32'sd1;
         4, 5: return $urandom_range(8) - 4;
         default: return $urandom;
      endcase
   endfunction

   function automatic record_type make_record(logic signed [31:0] key, logic [7:0] age);
      record_type r;
      r.key         = key;
      r.age         = age;
      r.name_first  = pick_name64();
      r.name_middle = pick_name64();
      r.name_tail   = pick_name32();
      return r;
   endfunction

   task automatic add_item(record_type r, bit last);
      load_item_type it;
      it.rec     = r;
      it.last_in = last;
      load_q.push_back(it);
   endtask

   task automatic add_random_set(int n);
      for (int i = 0; i < n; i++)
         add_item(make_record(pick_key(), 8'($urandom_range(255))), i == n - 1);
   endtask

   // stores one record and, on the last of a set, sorts and queues the results
   task automatic take_record(load_item_type it);
      record_type       tmp;
      sorted_entry_type e;
      if (held_count < DEPTH) begin
         held[held_count] = it.rec;
         held_count++;
      end else begin
         dropped = 1'b1;
      end
      if (it.last_in) begin
         for (int i = 0; i + 1 < held_count; i++)
            for (int j = i + 1; j < held_count; j++)
               if ($signed(held[i].key) > $signed(held[j].key)) begin
                  tmp     = held[i];
                  held[i] = held[j];
                  held[j] = tmp;
               end
         for (int k = 0; k < held_count; k++) begin
            e.rec      = held[k];
            e.last_out = (k == held_count - 1);
            e.overflow = dropped;
            sorted_q.push_back(e);
         end
         held_count = 0;
         dropped    = 1'b0;
      end
   endtask

   task automatic report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic int pace();
      int p;
      p = (total_items == 0) ? 0 : taken_count * 4 / total_items;
      return (p > 3) ? 3 : p;
   endfunction

   function automatic bit sender_idles();
      case (pace())
         1: return $urandom_range(99) < 76;
         3: return $urandom_range(99) < 8;
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit receiver_stalls();
      case (pace())
         2: return $urandom_range(99) < 76;
         3: return $urandom_range(99) < 8;
         default: return 1'b0;
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_live) begin
         if (load_q.size() != 0 && !sender_idles()) begin
            req_bus.key         <= load_q[0].rec.key;
            req_bus.age         <= load_q[0].rec.age;
            req_bus.name_first  <= load_q[0].rec.name_first;
            req_bus.name_middle <= load_q[0].rec.name_middle;
            req_bus.name_tail   <= load_q[0].rec.name_tail;
            req_bus.last_in     <= load_q[0].last_in;
            req_bus.valid       <= 1'b1;
            req_live = 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && hold_left == 0 && !receiver_stalls();
   end

   // long hold-off on the result side so the input backs up
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
      end else if (!reset && !hold_used && taken_count >= 20 && rsp_bus.valid === 1'b1
                   && load_q.size() != 0) begin
         hold_left = HOLD_CYCLES;
         hold_used = 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      sorted_entry_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (sorted_q.size() == 0) begin
            report($sformatf("unexpected result key %h", rsp_bus.sorted_key));
         end else begin
            want = sorted_q.pop_front();
            if (rsp_bus.sorted_key !== want.rec.key
                || rsp_bus.sorted_age !== want.rec.age
                || rsp_bus.sorted_name_first !== want.rec.name_first
                || rsp_bus.sorted_name_middle !== want.rec.name_middle
                || rsp_bus.sorted_name_tail !== want.rec.name_tail
                || rsp_bus.last_out !== want.last_out
                || rsp_bus.overflow !== want.overflow)
               report($sformatf({"expected key %h age %h name %h_%h_%h last %b ovf %b, ",
                                 "got key %h age %h name %h_%h_%h last %b ovf %b"},
                  want.rec.key, want.rec.age, want.rec.name_first, want.rec.name_middle,
                  want.rec.name_tail, want.last_out, want.overflow,
                  rsp_bus.sorted_key, rsp_bus.sorted_age, rsp_bus.sorted_name_first,
                  rsp_bus.sorted_name_middle, rsp_bus.sorted_name_tail,
                  rsp_bus.last_out, rsp_bus.overflow));
         end
      end
      if (!reset && req_bus.valid === 1'b1 && req_bus.ready === 1'b1) begin
         take_record(load_q.pop_front());
         taken_count++;
         req_live = 1'b0;
      end
   end

   initial begin
      record_type r;
      logic signed [31:0] mixed_keys[10];
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.key         = '0;
      req_bus.age         = '0;
      req_bus.name_first  = '0;
      req_bus.name_middle = '0;
      req_bus.name_tail   = '0;
      req_bus.last_in     = 1'b0;
      rsp_bus.ready       = 1'b0;
      held_count  = 0;
      dropped     = 1'b0;
      taken_count = 0;
      mismatches  = 0;
      req_live    = 1'b0;
      hold_left   = 0;
      hold_used   = 1'b0;

      // single-record sets at the field extremes
      r = '1;
      r.key = KEY_MAX;
      add_item(r, 1'b1);
      r = '0;
      r.key = KEY_MIN;
      add_item(r, 1'b1);

      // mixed signs, extremes and repeated keys
      mixed_keys = '{32'sd7, 32'sd3, 32'sd7, -32'sd2, 32'sd7, 32'sd3,
                     KEY_MAX, KEY_MIN, 32'sd0, -32'sd1};
      for (int i = 0; i < 10; i++)
         add_item(make_record(mixed_keys[i], 8'(i)), i == 9);

      // all keys equal
      for (int i = 0; i < 4; i++)
         add_item(make_record(-32'sd256, 8'(8'hf0 + i)), i == 3);

      // a full set, then two sets whose extra records, the last one too, are dropped
      add_random_set(DEPTH);
      add_random_set(DEPTH + 3);
      add_random_set(DEPTH + 1);

      while (load_q.size() < LOAD_ITEMS) begin
         if ($urandom_range(7) == 0)
            add_random_set($urandom_range(DEPTH + 4, DEPTH - 4));
         else
            add_random_set($urandom_range(10, 1));
      end
      total_items = load_q.size();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (load_q.size() != 0 || sorted_q.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatches == 0 && sorted_q.size() == 0)
         $display("record_sort_by_key_core verification clean");
      else
         $display("record_sort_by_key_core verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("record_sort_by_key_core verification failed");
      $finish;
   end

endmodule
